[rtl/sd_identification_sequencer_core_assert.svh]
// Assertion macros for the SD identification sequencer.
// Both expect clk and rst_n in scope at the point of use.
`ifndef SD_IDENTIFICATION_SEQUENCER_CORE_ASSERT_SVH
`define SD_IDENTIFICATION_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SDID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sdid_pkg.sv]
package sdid_pkg;

    localparam int unsigned CFG_LIMIT_W = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CNT_W       = 18;
    localparam int unsigned ATT_OUT_W   = 16;

    localparam logic [CNT_W-1:0]       CNT_MAX       = '1;
    localparam logic [CFG_LIMIT_W-1:0] LIMIT_RESET   = 16'd100;
    localparam logic [31:0]            ARG_CMD8      = 32'h0000_01AA;
    localparam logic [31:0]            ARG_ACMD41    = 32'h4000_0000;
    localparam logic [7:0]             R1_READY      = 8'h00;

    localparam logic [5:0] CMD_GO_IDLE        = 6'd0;
    localparam logic [5:0] CMD_SEND_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_APP            = 6'd55;
    localparam logic [5:0] ACMD_SEND_OP_COND  = 6'd41;
    localparam logic [5:0] CMD_READ_OCR       = 6'd58;
    localparam logic [5:0] CMD_SEND_CID       = 6'd10;
    localparam logic [5:0] CMD_SEND_CSD       = 6'd9;

    typedef enum logic {
        OP_START    = 1'b0,
        OP_COMPLETE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_INIT_ATTEMPTS   = 3'd0,
        REG_IS_PHYSICAL         = 3'd1,
        REG_ALLOW_PHYSICAL      = 3'd2,
        REG_EXPLICITLY_SELECTED = 3'd3,
        REG_IDENTIFICATION_ONLY = 3'd4,
        REG_OWNED_RESOURCES     = 3'd5,
        REG_CONFLICTING_OWNER   = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CMD0   = 3'd1,
        PH_CMD8   = 3'd2,
        PH_CMD55  = 3'd3,
        PH_ACMD41 = 3'd4,
        PH_CMD58  = 3'd5,
        PH_CMD10  = 3'd6,
        PH_CMD9   = 3'd7
    } phase_t;

    typedef enum logic [3:0] {
        ST_COMPLETE         = 4'd0,
        ST_INVALID_PLAN     = 4'd1,
        ST_PHYS_REJECTED    = 4'd2,
        ST_TARGET_REQUIRED  = 4'd3,
        ST_READONLY_REQUIRED = 4'd4,
        ST_RESOURCES_MISSING = 4'd5,
        ST_CONFLICT         = 4'd6,
        ST_XCHG_FAILED      = 4'd7,
        ST_INIT_TIMEOUT     = 4'd8
    } status_t;

    typedef struct packed {
        logic       is_physical;
        logic       allow_physical;
        logic       explicitly_selected;
        logic       identification_only;
        logic [7:0] owned_resources;
        logic       conflicting_owner;
    } policy_cfg_t;

    typedef struct packed {
        logic                 is_command;
        logic [5:0]           cmd_index;
        logic [31:0]          cmd_argument;
        status_t              status;
        logic [ATT_OUT_W-1:0] init_tries;
        logic [CNT_W-1:0]     cmds_sent;
        logic [CNT_W-1:0]     cmds_acked;
        logic [31:0]          cmd8_echo;
        logic [31:0]          ocr_word;
        logic                 physical_used;
    } result_t;

    function automatic logic [5:0] cmd_of_phase(input phase_t ph);
        logic [5:0] idx;
        case (ph)
            PH_CMD0:   idx = CMD_GO_IDLE;
            PH_CMD8:   idx = CMD_SEND_IF_COND;
            PH_CMD55:  idx = CMD_APP;
            PH_ACMD41: idx = ACMD_SEND_OP_COND;
            PH_CMD58:  idx = CMD_READ_OCR;
            PH_CMD10:  idx = CMD_SEND_CID;
            PH_CMD9:   idx = CMD_SEND_CSD;
            default:   idx = CMD_GO_IDLE;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] arg_of_phase(input phase_t ph);
        logic [31:0] arg;
        case (ph)
            PH_CMD8:   arg = ARG_CMD8;
            PH_ACMD41: arg = ARG_ACMD41;
            default:   arg = '0;
        endcase
        return arg;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

[rtl/sdid_policy.sv]
module sdid_policy #(
    parameter int unsigned REQUIRED_RESOURCE_MASK = 15,
    parameter int unsigned ATTEMPT_BITS           = 16
) (
    input  logic [sdid_pkg::CFG_LIMIT_W-1:0] max_init_attempts,
    input  sdid_pkg::policy_cfg_t            cfg,
    output logic [ATTEMPT_BITS-1:0]          limit,
    output sdid_pkg::status_t                start_status,
    output logic                             start_phys
);
    import sdid_pkg::*;

    localparam logic [CFG_LIMIT_W-1:0] LIMIT_CAP =
        CFG_LIMIT_W'((32'd1 << ATTEMPT_BITS) - 32'd1);
    localparam logic [7:0] NEED = 8'(REQUIRED_RESOURCE_MASK);

    // Saturate the programmed limit to what the attempt counter can hold.
    always_comb
    begin
        if (max_init_attempts > LIMIT_CAP)
            limit = '1;
        else
            limit = max_init_attempts[ATTEMPT_BITS-1:0];
    end

    // Plan check first, then the physical access policy in priority order.
    always_comb
    begin
        start_phys   = 1'b0;
        start_status = ST_COMPLETE;
        if (limit == '0)
        begin
            start_status = ST_INVALID_PLAN;
        end
        else
        begin
            start_phys = cfg.is_physical;
            if (cfg.is_physical)
            begin
                if (!cfg.allow_physical)
                    start_status = ST_PHYS_REJECTED;
                else if (!cfg.explicitly_selected)
                    start_status = ST_TARGET_REQUIRED;
                else if (!cfg.identification_only)
                    start_status = ST_READONLY_REQUIRED;
                else if ((cfg.owned_resources & NEED) != NEED)
                    start_status = ST_RESOURCES_MISSING;
                else if (cfg.conflicting_owner)
                    start_status = ST_CONFLICT;
            end
        end
    end

endmodule

[rtl/sdid_seq.sv]
module sdid_seq #(
    parameter int unsigned ATTEMPT_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  sdid_pkg::op_t           opcode,
    input  logic                    exchange_ok,
    input  logic [7:0]              r1,
    input  logic [31:0]             trailing,
    input  logic [ATTEMPT_BITS-1:0] limit,
    input  sdid_pkg::status_t       start_status,
    input  logic                    start_phys,
    output logic                    has_result,
    output sdid_pkg::result_t       res
);
    import sdid_pkg::*;

    phase_t                  phase_reg,     phase_next;
    logic [ATTEMPT_BITS-1:0] attempt_reg,   attempt_next;
    logic [CNT_W-1:0]        attempted_reg, attempted_next;
    logic [CNT_W-1:0]        completed_reg, completed_next;
    logic [31:0]             echo_reg,      echo_next;
    logic [31:0]             ocr_reg,       ocr_next;
    logic                    phys_reg,      phys_next;
    logic [ATTEMPT_BITS-1:0] attempt_inc;

    assign attempt_inc = attempt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            attempt_reg   <= '0;
            attempted_reg <= '0;
            completed_reg <= '0;
            echo_reg      <= '0;
            ocr_reg       <= '0;
            phys_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            attempt_reg   <= attempt_next;
            attempted_reg <= attempted_next;
            completed_reg <= completed_next;
            echo_reg      <= echo_next;
            ocr_reg       <= ocr_next;
            phys_reg      <= phys_next;
        end
    end

    // Next state
    always_comb
    begin
        phase_next     = phase_reg;
        attempt_next   = attempt_reg;
        attempted_next = attempted_reg;
        completed_next = completed_reg;
        echo_next      = echo_reg;
        ocr_next       = ocr_reg;
        phys_next      = phys_reg;
        if (fire)
        begin
            if (opcode == OP_START)
            begin
                phase_next     = PH_IDLE;
                attempt_next   = '0;
                attempted_next = '0;
                completed_next = '0;
                echo_next      = '0;
                ocr_next       = '0;
                phys_next      = start_phys;
                if (start_status == ST_COMPLETE)
                begin
                    phase_next     = PH_CMD0;
                    attempted_next = CNT_W'(1);
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (!exchange_ok)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    completed_next = sat_inc(completed_reg);
                    case (phase_reg)
                        PH_CMD0:
                            phase_next = PH_CMD8;
                        PH_CMD8:
                        begin
                            echo_next  = trailing;
                            phase_next = (attempt_reg >= limit) ? PH_IDLE : PH_CMD55;
                        end
                        PH_CMD55:
                            phase_next = PH_ACMD41;
                        PH_ACMD41:
                        begin
                            attempt_next = attempt_inc;
                            if (r1 == R1_READY)
                                phase_next = PH_CMD58;
                            else if (attempt_inc >= limit)
                                phase_next = PH_IDLE;
                            else
                                phase_next = PH_CMD55;
                        end
                        PH_CMD58:
                        begin
                            ocr_next   = trailing;
                            phase_next = PH_CMD10;
                        end
                        PH_CMD10:
                            phase_next = PH_CMD9;
                        default:
                            phase_next = PH_IDLE;
                    endcase
                    if (phase_next != PH_IDLE)
                        attempted_next = sat_inc(attempted_reg);
                end
            end
        end
    end

    // Outputs: a new phase means a command, a return to idle means a report.
    always_comb
    begin
        status_t rep_status;
        if (opcode == OP_START)
            rep_status = start_status;
        else if (!exchange_ok)
            rep_status = ST_XCHG_FAILED;
        else if (phase_reg == PH_CMD9)
            rep_status = ST_COMPLETE;
        else
            rep_status = ST_INIT_TIMEOUT;

        has_result         = fire && ((opcode == OP_START) || (phase_reg != PH_IDLE));
        res.is_command     = (phase_next != PH_IDLE);
        res.cmd_index      = cmd_of_phase(phase_next);
        res.cmd_argument   = arg_of_phase(phase_next);
        res.status         = res.is_command ? ST_COMPLETE : rep_status;
        res.init_tries     = ATT_OUT_W'(attempt_next);
        res.cmds_sent      = attempted_next;
        res.cmds_acked     = completed_next;
        res.cmd8_echo      = echo_next;
        res.ocr_word       = ocr_next;
        res.physical_used  = phys_next;
    end

endmodule

[rtl/sd_identification_sequencer_core.sv]
// SD card identification sequencer, host side (SPI-mode bring-up).
// Input channel (in_valid/in_ready): opcode start begins a run; opcode
// complete reports the outstanding exchange with exchange_ok, r1 and the
// trailing word. Output channel (out_valid/out_ready): each transaction is
// either the next command to issue (is_command 1) or a final run report
// with a status, plus the live counters, CMD8 echo and OCR.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no run transaction is in flight.
// Path: the input register captures on the accepting edge and the sequencer
// logic then loads the output register from it when the output slot is free.
// Throughput: one input transaction per cycle while out_ready stays high.
// A completion arriving while idle is dropped with no result.
// Reset: phase idle, counters and latches zero, attempt limit 100, all
// other policy registers zero.
// Stall: the output register holds its result; the input register takes
// one more transaction, then in_ready drops until out_ready returns.
`include "sd_identification_sequencer_core_assert.svh"

module sd_identification_sequencer_core #(
    parameter int unsigned REQUIRED_RESOURCE_MASK = 15,
    parameter int unsigned ATTEMPT_BITS           = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic                                exchange_ok,
    input  logic [7:0]                          r1,
    input  logic [31:0]                         trailing,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                is_command,
    output logic [5:0]                          cmd_index,
    output logic [31:0]                         cmd_argument,
    output logic [3:0]                          status,
    output logic [15:0]                         init_tries,
    output logic [17:0]                         cmds_sent,
    output logic [17:0]                         cmds_acked,
    output logic [31:0]                         cmd8_echo,
    output logic [31:0]                         ocr_word,
    output logic                                physical_used,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdid_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sdid_pkg::*;

    // Configuration registers
    logic [CFG_LIMIT_W-1:0] max_init_attempts_reg;
    policy_cfg_t            policy_reg;

    // Input register stage
    logic        s1_valid_reg, s1_valid_next;
    op_t         s1_opcode_reg;
    logic        s1_ok_reg;
    logic [7:0]  s1_r1_reg;
    logic [31:0] s1_trailing_reg;

    // Output register stage
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    logic                    in_fire;
    logic                    out_free;
    logic                    advance;
    logic [ATTEMPT_BITS-1:0] limit;
    status_t                 start_status;
    logic                    start_phys;
    logic                    has_result;
    result_t                 res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_init_attempts_reg <= LIMIT_RESET;
            policy_reg            <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_MAX_INIT_ATTEMPTS:   max_init_attempts_reg <= cfg_data[CFG_LIMIT_W-1:0];
                REG_IS_PHYSICAL:         policy_reg.is_physical <= cfg_data[0];
                REG_ALLOW_PHYSICAL:      policy_reg.allow_physical <= cfg_data[0];
                REG_EXPLICITLY_SELECTED: policy_reg.explicitly_selected <= cfg_data[0];
                REG_IDENTIFICATION_ONLY: policy_reg.identification_only <= cfg_data[0];
                REG_OWNED_RESOURCES:     policy_reg.owned_resources <= cfg_data[7:0];
                REG_CONFLICTING_OWNER:   policy_reg.conflicting_owner <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    // The output slot is free when empty or being drained this cycle; advance
    // the input stage only into a free slot.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Payload of the input stage needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_opcode_reg   <= op_t'(opcode);
            s1_ok_reg       <= exchange_ok;
            s1_r1_reg       <= r1;
            s1_trailing_reg <= trailing;
        end
    end

    sdid_policy #(
        .REQUIRED_RESOURCE_MASK (REQUIRED_RESOURCE_MASK),
        .ATTEMPT_BITS           (ATTEMPT_BITS)
    ) u_policy (
        .max_init_attempts (max_init_attempts_reg),
        .cfg               (policy_reg),
        .limit             (limit),
        .start_status      (start_status),
        .start_phys        (start_phys)
    );

    sdid_seq #(
        .ATTEMPT_BITS (ATTEMPT_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .opcode       (s1_opcode_reg),
        .exchange_ok  (s1_ok_reg),
        .r1           (s1_r1_reg),
        .trailing     (s1_trailing_reg),
        .limit        (limit),
        .start_status (start_status),
        .start_phys   (start_phys),
        .has_result   (has_result),
        .res          (res)
    );

    // Load a result on advance; drop the valid once the receiver takes it.
    always_comb
    begin
        if (advance)
            out_valid_next = has_result;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
            out_data_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign is_command    = out_data_reg.is_command;
    assign cmd_index     = out_data_reg.cmd_index;
    assign cmd_argument  = out_data_reg.cmd_argument;
    assign status        = out_data_reg.status;
    assign init_tries    = out_data_reg.init_tries;
    assign cmds_sent     = out_data_reg.cmds_sent;
    assign cmds_acked    = out_data_reg.cmds_acked;
    assign cmd8_echo     = out_data_reg.cmd8_echo;
    assign ocr_word      = out_data_reg.ocr_word;
    assign physical_used = out_data_reg.physical_used;

    // A report never carries a command index or argument.
    `SDID_ASSERT_NOW(a_report_no_cmd, out_valid && !is_command, cmd_index == CMD_GO_IDLE && cmd_argument == '0, "report carries a command")
    // A command always carries status complete.
    `SDID_ASSERT_NOW(a_cmd_status, out_valid && is_command, status == ST_COMPLETE, "command with nonzero status")
    // Completions can never outrun issued commands.
    `SDID_ASSERT_NOW(a_cnt_order, out_valid, cmds_acked <= cmds_sent, "completed exceeds attempted")
    // A stalled output keeps the input stage occupied.
    `SDID_ASSERT_NEXT(a_stall_hold, s1_valid_reg && out_valid_reg && !out_ready, s1_valid_reg, "input stage drained into a stalled output")

endmodule
